>>> design/gscs_pkg.sv
// Shared types, constants and the sigmoid lookup table for the graded synapse step.
// Used by the channel interfaces, the controller, the datapath and the top level.
package gscs_pkg;

    localparam int HILL_POWER         = 2;
    localparam int SIGMOID_TABLE_BITS = 10;

    localparam int TAB_LEN   = (1 << SIGMOID_TABLE_BITS) + 1;
    localparam int IDX_W     = SIGMOID_TABLE_BITS + 1;
    localparam int FRAC_BITS = 20 - SIGMOID_TABLE_BITS;

    localparam int PW_CNT_W  = (HILL_POWER > 1) ? $clog2(HILL_POWER) : 1;
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_SPAN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_SLOPE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_DECAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_DECAY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HILL_HALF   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GBAR        = 3'd7;

    typedef struct packed {
        logic signed [31:0] pre_voltage;
        logic signed [31:0] ca_fast_current;
        logic signed [31:0] ca_slow_current;
        logic signed [31:0] post_voltage;
        logic signed [31:0] reversal_potential;
    } t_in_item;

    typedef struct packed {
        logic        [30:0] conductance;
        logic signed [31:0] syn_current;
        logic        [16:0] hill_ratio;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_M_ARG, S_ARG, S_RD_A, S_RD_B, S_M_INT, S_SIG, S_M_SPAN, S_TGT,
        S_M_AV1, S_M_AV2, S_AV, S_ICA, S_M_DR1, S_M_DR2, S_DR,
        S_M_PL, S_M_PH, S_PW, S_DEN, S_NORM, S_DIV,
        S_M_COND, S_COND, S_M_CUR, S_CUR
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_M_ARG, OP_ARG, OP_RD_A, OP_RD_B, OP_M_INT, OP_SIG,
        OP_M_SPAN, OP_TGT, OP_M_AV1, OP_M_AV2, OP_AV, OP_ICA, OP_M_DR1, OP_M_DR2,
        OP_DR, OP_M_PL, OP_M_PH, OP_PW, OP_DEN, OP_NORM, OP_DIV,
        OP_M_COND, OP_COND, OP_M_CUR, OP_CUR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic first;
    } t_cmd;

    typedef struct packed {
        logic den_big;
        logic out_busy;
    } t_status;

    typedef logic [16:0] t_tab [TAB_LEN];

    // Shift-subtract divide, evaluated only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Logistic 1/(1+exp(x)) sampled over [-8, 8] in Q0.16
    function automatic t_tab build_sig_tab();
        t_tab         tab;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [63:0]  r;
        logic [63:0]  e;
        logic [63:0]  den;
        logic [63:0]  q;
        logic [127:0] prod;
        int           sh;
        int           half;
        sh   = SIGMOID_TABLE_BITS - 4;
        half = 1 << (SIGMOID_TABLE_BITS - 1);
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        for (int n = 1; n <= 12; n++) begin
            term = udiv64(term >> sh, 64'(n));
            if ((n % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r = pos - neg;
        e = 64'd1 << 32;
        for (int m = 0; m <= half; m++) begin
            den = (64'd1 << 32) + e;
            q = udiv64((e << 16) + (den >> 1), den);
            tab[half + m] = q[16:0];
            q = udiv64((64'd1 << 48) + (den >> 1), den);
            tab[half - m] = q[16:0];
            prod = {64'd0, e} * {64'd0, r} + (128'd1 << 31);
            e = prod[95:32];
        end
        return tab;
    endfunction

    localparam t_tab SIG_TAB = build_sig_tab();

endpackage

>>> design/gscs_in_if.sv
// Input channel of the graded synapse step: valid, ready and one input item.
// Depends on gscs_pkg for the item type.
interface gscs_in_if;
    import gscs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/gscs_out_if.sv
// Output channel of the graded synapse step: valid, ready and one result item.
// Depends on gscs_pkg for the item type.
interface gscs_out_if;
    import gscs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/graded_synapse_conductance_step_top.sv
// Each accepted item is worked through to its result before the next is taken; the Hill
// denominator is first shifted right n times (n in 0..16) to bring it below 2^47.
// The steps run on the single shared multiplier, the two sigmoid ROM reads and the
// 17-step restoring divider.
// A new item is taken while the last result waits; the next result holds until it leaves.
// Reset (synchronous, active low) restores the config defaults and zeroes the state.
module graded_synapse_conductance_step_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gscs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gscs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    gscs_in_if.sink                            i_in,
    gscs_out_if.source                         o_out
);
    import gscs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence the step
    gscs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Compute the step
    gscs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_CUR) |-> !(o_out.valid && !o_out.ready))
        else $error("result overwritten while waiting");

    // A result appears only after the final step
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.op == OP_CUR))
        else $error("result valid without final step");

    // Hill ratio stays within one
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.hill_ratio <= 17'd65536))
        else $error("hill ratio above one");

endmodule

>>> design/gscs_ctrl.sv
// Controller of the graded synapse step: sequences the datapath one step per state.
// Depends on gscs_pkg for state, command and status types.
module gscs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gscs_pkg::t_status i_status,
    output gscs_pkg::t_cmd    o_cmd
);
    import gscs_pkg::*;

    localparam logic [PW_CNT_W-1:0]  PW_LAST  = PW_CNT_W'(HILL_POWER - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    t_state                r_state;
    t_state                n_state;
    logic [PW_CNT_W-1:0]   r_pw_cnt;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Count power iterations and divide steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_cnt  <= '0;
            r_div_cnt <= '0;
        end else begin
            case (r_state)
                S_DR:    r_pw_cnt  <= '0;
                S_PW:    r_pw_cnt  <= r_pw_cnt + 1'b1;
                S_NORM:  r_div_cnt <= '0;
                S_DIV:   r_div_cnt <= r_div_cnt + 1'b1;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_M_ARG;
            S_M_ARG:  n_state = S_ARG;
            S_ARG:    n_state = S_RD_A;
            S_RD_A:   n_state = S_RD_B;
            S_RD_B:   n_state = S_M_INT;
            S_M_INT:  n_state = S_SIG;
            S_SIG:    n_state = S_M_SPAN;
            S_M_SPAN: n_state = S_TGT;
            S_TGT:    n_state = S_M_AV1;
            S_M_AV1:  n_state = S_M_AV2;
            S_M_AV2:  n_state = S_AV;
            S_AV:     n_state = S_ICA;
            S_ICA:    n_state = S_M_DR1;
            S_M_DR1:  n_state = S_M_DR2;
            S_M_DR2:  n_state = S_DR;
            S_DR:     n_state = S_M_PL;
            S_M_PL:   n_state = S_M_PH;
            S_M_PH:   n_state = S_PW;
            S_PW:     n_state = (r_pw_cnt == PW_LAST) ? S_DEN : S_M_PL;
            S_DEN:    n_state = S_NORM;
            S_NORM:   n_state = i_status.den_big ? S_NORM : S_DIV;
            S_DIV:    n_state = (r_div_cnt == DIV_LAST) ? S_M_COND : S_DIV;
            S_M_COND: n_state = S_COND;
            S_COND:   n_state = S_M_CUR;
            S_M_CUR:  n_state = S_CUR;
            S_CUR:    n_state = i_status.out_busy ? S_CUR : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.first = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_M_ARG:  o_cmd.op = OP_M_ARG;
            S_ARG:    o_cmd.op = OP_ARG;
            S_RD_A:   o_cmd.op = OP_RD_A;
            S_RD_B:   o_cmd.op = OP_RD_B;
            S_M_INT:  o_cmd.op = OP_M_INT;
            S_SIG:    o_cmd.op = OP_SIG;
            S_M_SPAN: o_cmd.op = OP_M_SPAN;
            S_TGT:    o_cmd.op = OP_TGT;
            S_M_AV1:  o_cmd.op = OP_M_AV1;
            S_M_AV2:  o_cmd.op = OP_M_AV2;
            S_AV:     o_cmd.op = OP_AV;
            S_ICA:    o_cmd.op = OP_ICA;
            S_M_DR1:  o_cmd.op = OP_M_DR1;
            S_M_DR2:  o_cmd.op = OP_M_DR2;
            S_DR:     o_cmd.op = OP_DR;
            S_M_PL:   o_cmd.op = OP_M_PL;
            S_M_PH:   o_cmd.op = OP_M_PH;
            S_PW:     o_cmd.op = OP_PW;
            S_DEN:    o_cmd.op = OP_DEN;
            S_NORM:   o_cmd.op = OP_NORM;
            S_DIV: begin
                o_cmd.op    = OP_DIV;
                o_cmd.first = (r_div_cnt == '0);
            end
            S_M_COND: o_cmd.op = OP_M_COND;
            S_COND:   o_cmd.op = OP_COND;
            S_M_CUR:  o_cmd.op = OP_M_CUR;
            S_CUR:    o_cmd.op = i_status.out_busy ? OP_NONE : OP_CUR;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> design/gscs_datapath.sv
// Datapath of the graded synapse step: config registers, state, shared multiplier,
// sigmoid ROM, restoring divider and the output register. Depends on gscs_pkg.
module gscs_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gscs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gscs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  gscs_pkg::t_in_item                 i_in_data,
    input  gscs_pkg::t_cmd                     i_cmd,
    output gscs_pkg::t_status                  o_status,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output gscs_pkg::t_out_item                o_out_data
);
    import gscs_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return $signed(v[31:0]);
    endfunction

    // Configuration registers
    logic signed [31:0] r_sig_base;
    logic signed [31:0] r_sig_span;
    logic signed [31:0] r_sig_slope;
    logic signed [31:0] r_sig_offset;
    logic [15:0]        r_avail_decay;
    logic [15:0]        r_drive_decay;
    logic [47:0]        r_hill_half;
    logic [30:0]        r_gbar;

    // Step state
    logic signed [31:0] r_avail;
    logic [30:0]        r_drive;

    // Working registers
    logic signed [31:0] r_a;
    logic signed [32:0] r_fs;
    logic signed [32:0] r_dv;
    logic signed [65:0] r_prod;
    logic signed [65:0] r_acc;
    logic [IDX_W-1:0]   r_idx;
    logic [FRAC_BITS-1:0] r_frac;
    logic [16:0]        r_rom;
    logic [16:0]        r_ta;
    logic               r_dec;
    logic [16:0]        r_s;
    logic signed [31:0] r_tgt;
    logic [30:0]        r_ica;
    logic [62:0]        r_p;
    logic [62:0]        r_num;
    logic [62:0]        r_den;
    logic [47:0]        r_rem;
    logic [16:0]        r_q;
    logic               r_zero;
    logic [30:0]        r_cond;

    // Output register
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [32:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [65:0] w_prod;
    logic [16:0]        w_tdiff;
    logic [16:0]        w_ratio;
    logic [IDX_W-1:0]   w_rom_addr;
    logic signed [32:0] w_pre_sum;
    logic signed [65:0] w_x;
    logic [19:0]        w_xs;
    logic [19:0]        w_u;
    logic [16:0]        w_d;
    logic signed [65:0] w_tgt_sum;
    logic signed [65:0] w_mix;
    logic signed [33:0] w_ica;
    logic [94:0]        w_full;
    logic [47:0]        w_t;
    logic               w_ge;

    assign w_tdiff = (r_ta >= r_rom) ? (r_ta - r_rom) : (r_rom - r_ta);
    assign w_ratio = r_zero ? 17'd0 : r_q;

    // Select multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_M_ARG: begin
                w_mul_a = 33'(r_sig_slope);
                w_mul_b = 33'(r_a);
            end
            OP_M_INT: begin
                w_mul_a = $signed({16'd0, w_tdiff});
                w_mul_b = $signed(33'(r_frac));
            end
            OP_M_SPAN: begin
                w_mul_a = 33'(r_sig_span);
                w_mul_b = $signed({16'd0, r_s});
            end
            OP_M_AV1: begin
                w_mul_a = 33'(r_avail);
                w_mul_b = $signed({17'd0, r_avail_decay});
            end
            OP_M_AV2: begin
                w_mul_a = 33'(r_tgt);
                w_mul_b = $signed({16'd0, 17'h10000 - {1'b0, r_avail_decay}});
            end
            OP_M_DR1: begin
                w_mul_a = $signed({2'd0, r_drive});
                w_mul_b = $signed({17'd0, r_drive_decay});
            end
            OP_M_DR2: begin
                w_mul_a = $signed({2'd0, r_ica});
                w_mul_b = $signed({16'd0, 17'h10000 - {1'b0, r_drive_decay}});
            end
            OP_M_PL: begin
                w_mul_a = $signed({1'b0, r_p[31:0]});
                w_mul_b = $signed({2'd0, r_drive});
            end
            OP_M_PH: begin
                w_mul_a = $signed({2'd0, r_p[62:32]});
                w_mul_b = $signed({2'd0, r_drive});
            end
            OP_M_COND: begin
                w_mul_a = $signed({2'd0, r_gbar});
                w_mul_b = $signed({16'd0, w_ratio});
            end
            OP_M_CUR: begin
                w_mul_a = r_dv;
                w_mul_b = $signed({2'd0, r_cond});
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Register the product; hold it while idle or stalled on the final step
    always_ff @(posedge i_clk) begin
        if (i_cmd.op != OP_NONE) begin
            r_prod <= w_prod;
        end
    end

    // Sigmoid ROM, registered read
    assign w_rom_addr = (i_cmd.op == OP_RD_B) ? (r_idx + 1'b1) : r_idx;

    always_ff @(posedge i_clk) begin
        r_rom <= SIG_TAB[w_rom_addr];
    end

    // Step arithmetic helpers
    assign w_pre_sum = 33'(i_in_data.pre_voltage) + 33'(r_sig_offset);
    assign w_x       = r_prod >>> 16;

    always_comb begin
        if (w_x < -66'sd524288) begin
            w_xs = 20'h80000;
        end else if (w_x > 66'sd524287) begin
            w_xs = 20'h7ffff;
        end else begin
            w_xs = w_x[19:0];
        end
    end

    assign w_u       = {~w_xs[19], w_xs[18:0]};
    assign w_d       = r_prod[FRAC_BITS+16:FRAC_BITS];
    assign w_tgt_sum = 66'(r_sig_base) + (r_prod >>> 16);
    assign w_mix     = (r_acc + r_prod) >>> 16;
    assign w_ica     = 34'(r_fs) - 34'(r_avail);
    assign w_full    = {31'd0, r_acc[63:0]} + {r_prod[62:0], 32'd0};
    assign w_t       = i_cmd.first ? r_num[47:0] : {r_rem[46:0], 1'b0};
    assign w_ge      = (w_t >= r_den[47:0]);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_base    <= 32'sd0;
            r_sig_span    <= 32'sd65536;
            r_sig_slope   <= 32'sd65536;
            r_sig_offset  <= 32'sd0;
            r_avail_decay <= 16'hffff;
            r_drive_decay <= 16'hffff;
            r_hill_half   <= 48'd65536;
            r_gbar        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIG_BASE:    r_sig_base    <= $signed(i_cfg_data[31:0]);
                CFG_SIG_SPAN:    r_sig_span    <= $signed(i_cfg_data[31:0]);
                CFG_SIG_SLOPE:   r_sig_slope   <= $signed(i_cfg_data[31:0]);
                CFG_SIG_OFFSET:  r_sig_offset  <= $signed(i_cfg_data[31:0]);
                CFG_AVAIL_DECAY: r_avail_decay <= i_cfg_data[15:0];
                CFG_DRIVE_DECAY: r_drive_decay <= i_cfg_data[15:0];
                CFG_HILL_HALF:   r_hill_half   <= i_cfg_data[47:0];
                CFG_GBAR:        r_gbar        <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Advance availability and drive state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail <= '0;
            r_drive <= '0;
        end else begin
            case (i_cmd.op)
                OP_AV: r_avail <= sat32(w_mix);
                OP_DR: begin
                    if (w_mix < 66'sd0) begin
                        r_drive <= '0;
                    end else if (w_mix > 66'sd2147483647) begin
                        r_drive <= 31'h7fffffff;
                    end else begin
                        r_drive <= w_mix[30:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Step through the working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_a  <= sat32(66'(w_pre_sum));
                r_fs <= 33'(i_in_data.ca_fast_current) + 33'(i_in_data.ca_slow_current);
                r_dv <= 33'(i_in_data.reversal_potential) - 33'(i_in_data.post_voltage);
            end
            OP_ARG: begin
                r_idx  <= {1'b0, w_u[19:FRAC_BITS]};
                r_frac <= w_u[FRAC_BITS-1:0];
            end
            OP_RD_B:  r_ta  <= r_rom;
            OP_M_INT: r_dec <= (r_ta >= r_rom);
            OP_SIG:   r_s   <= r_dec ? (r_ta - w_d) : (r_ta + w_d);
            OP_TGT:   r_tgt <= sat32(w_tgt_sum);
            OP_M_AV2: r_acc <= r_prod;
            OP_ICA: begin
                if (w_ica < 34'sd0) begin
                    r_ica <= '0;
                end else if (w_ica > 34'sd2147483647) begin
                    r_ica <= 31'h7fffffff;
                end else begin
                    r_ica <= w_ica[30:0];
                end
            end
            OP_M_DR2: r_acc <= r_prod;
            OP_DR:    r_p   <= 63'd65536;
            OP_M_PH:  r_acc <= r_prod;
            OP_PW: begin
                // cap the power on 64-bit overflow
                if (w_full[94:64] != '0) begin
                    r_p <= 63'd1 << 62;
                end else begin
                    r_p <= {15'd0, w_full[63:16]};
                end
            end
            OP_DEN: begin
                r_num  <= r_p;
                r_den  <= r_p + {15'd0, r_hill_half};
                r_zero <= (r_p == '0) && (r_hill_half == '0);
            end
            OP_NORM: begin
                if (o_status.den_big) begin
                    r_num <= r_num >> 1;
                    r_den <= r_den >> 1;
                end
            end
            OP_DIV: begin
                r_rem <= w_ge ? (w_t - r_den[47:0]) : w_t;
                r_q   <= {r_q[15:0], w_ge};
            end
            OP_COND: r_cond <= r_prod[46:16];
            default: ;
        endcase
    end

    // Output register: load the result item, drop it on handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_CUR) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CUR) begin
            r_out.conductance <= r_cond;
            r_out.syn_current <= sat32(r_prod >>> 16);
            r_out.hill_ratio  <= w_ratio;
        end
    end

    assign o_status.den_big  = (r_den[62:47] != '0);
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

>>> dv/graded_synapse_conductance_step_top_tb.sv
// Self-checking testbench for the graded synapse conductance step block.
// Depends on gscs_pkg and the gscs_in_if / gscs_out_if channel interfaces.
module graded_synapse_conductance_step_top_tb;
    import gscs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RX_HOLD_CYCLES = 300;
    localparam longint ARG_LIM    = 524288;
    localparam longint POW_CAP    = 64'h4000_0000_0000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    gscs_in_if  in_ch ();
    gscs_out_if out_ch ();

    graded_synapse_conductance_step_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
    end

    // Predictor state and configuration copy
    logic [16:0] logistic_tab [TAB_LEN];
    logic signed [31:0] m_base, m_span, m_slope, m_offset;
    logic [15:0] m_avail_decay, m_drive_decay;
    logic [47:0] m_hill_half;
    logic [30:0] m_gbar;
    longint m_avail, m_drive;

    t_out_item expected_results [$];
    int  errors;
    int  n_sent, n_checked;
    int  idle_pct;
    bit  rx_hold;
    int  quiet_cycles;

    // Helpers for fixed-point arithmetic
    function automatic longint floor_sh16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Build the logistic table with the same integer recipe
    task automatic build_logistic_tab();
        logic [63:0] term, pos, neg, r, e, den;
        logic [127:0] prod;
        int sh, half;
        sh = SIGMOID_TABLE_BITS - 4;
        half = 1 << (SIGMOID_TABLE_BITS - 1);
        term = 64'd1 << 32;
        pos = term;
        neg = 0;
        for (int n = 1; n <= 12; n++) begin
            term = (term >> sh) / n;
            if (n % 2) neg += term; else pos += term;
        end
        r = pos - neg;
        e = 64'd1 << 32;
        for (int m = 0; m <= half; m++) begin
            den = (64'd1 << 32) + e;
            logistic_tab[half + m] = 17'(((e << 16) + (den >> 1)) / den);
            logistic_tab[half - m] = 17'(((64'd1 << 48) + (den >> 1)) / den);
            prod = {64'd0, e} * {64'd0, r} + (128'd1 << 31);
            e = prod[95:32];
        end
    endtask

    task automatic reset_model();
        m_base = 0; m_span = 65536; m_slope = 65536; m_offset = 0;
        m_avail_decay = 16'hffff; m_drive_decay = 16'hffff;
        m_hill_half = 48'd65536; m_gbar = 0;
        m_avail = 0; m_drive = 0;
    endtask

    function automatic logic [31:0] logistic_lookup(longint x);
        int fb;
        logic [31:0] u, idx, frac, a, b, d;
        fb = 20 - SIGMOID_TABLE_BITS;
        if (x < -ARG_LIM) x = -ARG_LIM;
        if (x > ARG_LIM - 1) x = ARG_LIM - 1;
        u = 32'(x + ARG_LIM);
        idx = u >> fb;
        frac = u & ((32'd1 << fb) - 1);
        a = logistic_tab[idx];
        b = logistic_tab[idx + 1];
        if (a >= b) begin
            d = 32'((64'(a - b) * frac) >> fb);
            return a - d;
        end
        d = 32'((64'(b - a) * frac) >> fb);
        return a + d;
    endfunction

    function automatic logic [31:0] hill_ratio_of(logic [63:0] drive);
        logic [63:0] p, num, den;
        p = 65536;
        for (int i = 0; i < HILL_POWER; i++) begin
            if (drive != 0 && p > 64'hffff_ffff_ffff_ffff / drive) p = POW_CAP;
            else p = (p * drive) >> 16;
            if (p > POW_CAP) p = POW_CAP;
        end
        num = p;
        den = p + {16'd0, m_hill_half};
        if (den == 0) return 0;
        while (den >= (64'd1 << 47)) begin
            num >>= 1;
            den >>= 1;
        end
        return 32'((num << 16) / den);
    endfunction

    // Advance the predictor by one time step
    function automatic t_out_item predict_step(t_in_item it);
        t_out_item res;
        longint x, target, acc, ica, cur;
        logic [31:0] s, ratio;
        logic [63:0] cond;
        x = floor_sh16(longint'(m_slope) *
            sat32(longint'(it.pre_voltage) + longint'(m_offset)));
        s = logistic_lookup(x);
        target = sat32(longint'(m_base) + floor_sh16(longint'(m_span) * longint'({32'd0, s})));
        acc = m_avail * longint'({48'd0, m_avail_decay})
            + target * (65536 - longint'({48'd0, m_avail_decay}));
        m_avail = sat32(floor_sh16(acc));
        ica = longint'(it.ca_fast_current) + longint'(it.ca_slow_current) - m_avail;
        if (ica < 0) ica = 0;
        if (ica > 64'sd2147483647) ica = 64'sd2147483647;
        acc = m_drive * longint'({48'd0, m_drive_decay})
            + ica * (65536 - longint'({48'd0, m_drive_decay}));
        acc = floor_sh16(acc);
        if (acc < 0) acc = 0;
        m_drive = sat32(acc);
        ratio = hill_ratio_of(64'(m_drive));
        cond = (64'(m_gbar) * 64'(ratio)) >> 16;
        cur = sat32(floor_sh16((longint'(it.reversal_potential) -
            longint'(it.post_voltage)) * longint'(cond)));
        res.conductance = cond[30:0];
        res.syn_current = cur[31:0];
        res.hill_ratio  = ratio[16:0];
        return res;
    endfunction

    // Write one register in the block and in the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SIG_BASE:    m_base = val[31:0];
            CFG_SIG_SPAN:    m_span = val[31:0];
            CFG_SIG_SLOPE:   m_slope = val[31:0];
            CFG_SIG_OFFSET:  m_offset = val[31:0];
            CFG_AVAIL_DECAY: m_avail_decay = val[15:0];
            CFG_DRIVE_DECAY: m_drive_decay = val[15:0];
            CFG_HILL_HALF:   m_hill_half = val[47:0];
            CFG_GBAR:        m_gbar = val[30:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Send one item, idling at random first
    task automatic send_item(t_in_item it);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.push_back(predict_step(it));
        n_sent++;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_edge32();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(65536 * 8);
            4: return -$urandom_range(65536 * 8);
            default: return $urandom;
        endcase
    endfunction

    // Mostly physiological ranges, some extremes
    function automatic t_in_item rand_item();
        t_in_item it;
        if ($urandom_range(9) < 7) begin
            it.pre_voltage        = $signed($urandom_range(20 << 16)) - (10 << 16);
            it.ca_fast_current    = $signed($urandom_range(8 << 16)) - (2 << 16);
            it.ca_slow_current    = $signed($urandom_range(8 << 16)) - (2 << 16);
            it.post_voltage       = $signed($urandom_range(200 << 16)) - (100 << 16);
            it.reversal_potential = $signed($urandom_range(200 << 16)) - (100 << 16);
        end else begin
            it.pre_voltage        = rand_edge32();
            it.ca_fast_current    = rand_edge32();
            it.ca_slow_current    = rand_edge32();
            it.post_voltage       = rand_edge32();
            it.reversal_potential = rand_edge32();
        end
        return it;
    endfunction

    task automatic apply_config(logic [31:0] base, logic [31:0] span, logic [31:0] slope,
                                logic [31:0] offs, logic [15:0] ad, logic [15:0] dd,
                                logic [47:0] hh, logic [30:0] gb);
        write_reg(CFG_SIG_BASE, 48'(base));
        write_reg(CFG_SIG_SPAN, 48'(span));
        write_reg(CFG_SIG_SLOPE, 48'(slope));
        write_reg(CFG_SIG_OFFSET, 48'(offs));
        write_reg(CFG_AVAIL_DECAY, 48'(ad));
        write_reg(CFG_DRIVE_DECAY, 48'(dd));
        write_reg(CFG_HILL_HALF, hh);
        write_reg(CFG_GBAR, 48'(gb));
    endtask

    // Field extremes at defaults and at extreme settings
    task automatic test_directed();
        t_in_item it;
        it = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        send_item(it);
        it = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        send_item(it);
        send_item('0);
        wait_drained();
        // zero Hill constant: zero over zero, then huge drive for power overflow
        apply_config(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     16'd0, 16'd0, 48'd0, 31'h7fff_ffff);
        send_item('0);
        it = '{32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        for (int i = 0; i < 4; i++) send_item(it);
        wait_drained();
        // widest Hill constant forces the long normalization
        apply_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     16'hffff, 16'd1, 48'hffff_ffff_ffff, 31'h7fff_ffff);
        for (int i = 0; i < 6; i++) send_item(it);
        send_item('{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000});
        wait_drained();
        // out-of-range index is ignored; no index is unused for 3 bits, so rewrite
        apply_config(0, 65536, 65536 * 2, 0, 16'd60000, 16'd50000, 48'd1 << 30, 31'd65536);
        for (int i = 0; i < 8; i++) send_item(rand_item());
        wait_drained();
    endtask

    // Random items across several settings
    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 300 == 0) begin
                wait_drained();
                apply_config($urandom, $urandom, $urandom_range(65536 * 4),
                             $signed($urandom_range(65536 * 4)) - 131072,
                             16'($urandom), 16'($urandom),
                             48'({$urandom, $urandom} >> $urandom_range(16, 63)),
                             31'($urandom));
            end
            idle_pct = (k >= 600 && k < 900) ? 0 : 7;
            send_item(rand_item());
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender fills the block, then the sender pauses
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 6; i++) send_item(rand_item());
        wait_drained();
        for (int i = 0; i < 4; i++) send_item(rand_item());
        wait_drained();
    endtask

    // Drive the result ready with random stalls
    always @(posedge i_clk) begin
        if (rx_hold) out_ch.ready <= 1'b0;
        else out_ch.ready <= (idle_pct == 0) || ($urandom_range(99) >= 7);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result act=%h", $realtime, out_ch.data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (out_ch.data.conductance !== want.conductance) begin
                    $display("%0t conductance exp=%h act=%h", $realtime,
                             want.conductance, out_ch.data.conductance);
                    errors++;
                end
                if (out_ch.data.syn_current !== want.syn_current) begin
                    $display("%0t syn_current exp=%h act=%h", $realtime,
                             want.syn_current, out_ch.data.syn_current);
                    errors++;
                end
                if (out_ch.data.hill_ratio !== want.hill_ratio) begin
                    $display("%0t hill_ratio exp=%h act=%h", $realtime,
                             want.hill_ratio, out_ch.data.hill_ratio);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        errors = 0; n_sent = 0; n_checked = 0; idle_pct = 7; rx_hold = 1'b0;
        quiet_cycles = 0;
        build_logistic_tab();
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1820);
        if (expected_results.size() != 0) errors++;
        $display("covered %0d steps, %0d results checked over many register settings",
                 n_sent, n_checked);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
